/* hdl/brc_pkg.sv */
`timescale 1ns / 1ps
// Package for the balance robot controller: widths, constants, types.
// No dependencies; imported by the multiplier, divider, top level and testbench.
package brc_pkg;

  localparam int CALIB_SAMPLES = 100;
  localparam int DRIVE_LIMIT   = 100;

  // serial multiplier operand and product widths
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // calibration divide: batch sum shifted up by 16 fraction bits
  localparam int SUM_W   = 17;
  localparam int DIVD_W  = SUM_W + 16;
  localparam int OFF_W   = 26;
  localparam int ACC_W   = 70;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RATE_GAIN     = 3'd0,
    CFG_ANGLE_GAIN    = 3'd1,
    CFG_SPEED_GAIN    = 3'd2,
    CFG_POSITION_GAIN = 3'd3,
    CFG_OFFSET_TRACK  = 3'd4,
    CFG_TICK_INTERVAL = 3'd5,
    CFG_TICK_RATE     = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_DIV,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_t;

  // multiplier request and response
  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] p;
  } mul_rsp_t;

endpackage

/* hdl/brc_serial_mul.sv */
`timescale 1ns / 1ps
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on brc_pkg.
module brc_serial_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  brc_pkg::mul_req_t req,
  output brc_pkg::mul_rsp_t rsp
);
  import brc_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [MUL_P_W-1:0] acc_r;
  logic signed [MUL_P_W-1:0] a_r;
  logic [MUL_B_W-1:0]        b_r;
  logic signed [MUL_P_W-1:0] addend;
  logic                      last;

  assign last   = (cnt_r == CNT_W'(MUL_B_W - 1));
  assign addend = b_r[0] ? a_r : '0;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: the sign bit of b carries negative weight
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      a_r   <= MUL_P_W'(req.a);
      b_r   <= req.b;
    end else if (busy_r) begin
      acc_r <= last ? acc_r - addend : acc_r + addend;
      a_r   <= a_r <<< 1;
      b_r   <= b_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

/* hdl/brc_const_div.sv */
`timescale 1ns / 1ps
// Restoring divider by the batch length, one quotient bit per cycle.
// Depends on brc_pkg.
module brc_const_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [brc_pkg::DIVD_W-1:0]  dividend,
  output logic                        done,
  output logic [brc_pkg::OFF_W-1:0]   quotient
);
  import brc_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);
  localparam int REM_W = $clog2(CALIB_SAMPLES);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] sh_r;
  logic [REM_W-1:0]  rem_r;
  logic [OFF_W-1:0]  quo_r;
  logic [REM_W:0]    trial;
  logic              qbit;

  assign trial = {rem_r, sh_r[DIVD_W-1]};
  assign qbit  = (trial >= (REM_W+1)'(CALIB_SAMPLES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift in one dividend bit, subtract divisor when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_r << 1;
      rem_r <= qbit ? REM_W'(trial - (REM_W+1)'(CALIB_SAMPLES)) : REM_W'(trial);
      quo_r <= {quo_r[OFF_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* hdl/balance_robot_controller.sv */
`timescale 1ns / 1ps
// Top level of the balance controller: control sequencer and state.
// Depends on brc_pkg, brc_serial_mul and brc_const_div.
//
// One result per input tick. A calibrating tick passes from the calibration
// state to the output state, or through the offset divide when its batch
// completes with a spread of at most 1 (the offset divide runs one quotient bit
// per cycle). A balancing tick runs eight products through one bit-serial
// multiplier, one after another, then forms the drive in the finish state
// before the output state. A new tick is taken once the previous result has
// been moved into the output register; the output register holds a result
// until it is taken. Configuration writes are taken every cycle.
module balance_robot_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_gyro_sample,
  input  logic signed [23:0] in_left_count,
  input  logic signed [23:0] in_right_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [7:0] out_drive,
  output logic        out_calibrating,
  output logic [9:0]  out_batch_spread,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import brc_pkg::*;

  state_t state_r, state_nxt;

  // configuration
  logic signed [15:0] rate_gain_r, angle_gain_r, speed_gain_r, position_gain_r;
  logic [15:0]        track_r, interval_r;
  logic [9:0]         tick_rate_r;

  // controller state
  logic [OFF_W-1:0]   offset_r;
  logic signed [31:0] angle_r;
  logic signed [24:0] wpos_r;
  logic [SUM_W-1:0]   sum_r;
  logic [9:0]         min_r, max_r, spread_r;
  logic [6:0]         count_r;
  logic               in_cal_r;

  // tick working registers
  logic [9:0]         g_r;
  logic signed [23:0] left_r, right_r;
  logic [OFF_W-1:0]   tmp_r;
  logic signed [26:0] rate_r;
  logic signed [35:0] sp_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [2:0]         step_r;
  logic               mul_run_r;
  logic signed [7:0]  res_drive_r;

  // output register
  logic               out_valid_r;
  logic signed [7:0]  out_drive_r;
  logic               out_cal_r;
  logic [9:0]         out_spread_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic              div_start;
  logic              div_done;
  logic [OFF_W-1:0]  div_q;

  // calibration batch update
  logic [SUM_W-1:0] sum_nxt;
  logic [9:0]       min_nxt, max_nxt, diff_mm;
  logic [6:0]       count_nxt;
  logic             batch_end, batch_good;

  assign sum_nxt    = sum_r + SUM_W'(g_r);
  assign min_nxt    = (g_r < min_r) ? g_r : min_r;
  assign max_nxt    = (g_r > max_r) ? g_r : max_r;
  assign count_nxt  = count_r + 1'b1;
  assign diff_mm    = max_nxt - min_nxt;
  assign batch_end  = (count_nxt >= 7'(CALIB_SAMPLES));
  assign batch_good = (diff_mm <= 10'd1);

  // balancing datapath pieces
  logic signed [24:0] pos_now;
  logic signed [25:0] pos_diff;
  logic [OFF_W-1:0]   off_new;
  logic signed [39:0] angle_sum;
  logic [16:0]        track_c;

  assign pos_now  = 25'(left_r) + 25'(right_r);
  assign pos_diff = 26'(pos_now) - 26'(wpos_r);
  assign off_new  = mrsp.p[OFF_W-1:0] + tmp_r;
  assign angle_sum = 40'(angle_r) + 40'($signed(mrsp.p[MUL_P_W-1:16]));
  assign track_c  = 17'h10000 - {1'b0, track_r};

  // operand select per product
  always_comb begin
    mreq.start = (state_r == ST_MUL) && !mul_run_r;
    case (step_r)
      3'd0: begin
        mreq.a = MUL_A_W'({1'b0, offset_r});
        mreq.b = MUL_B_W'({1'b0, track_c});
      end
      3'd1: begin
        mreq.a = MUL_A_W'({1'b0, g_r});
        mreq.b = MUL_B_W'({1'b0, track_r});
      end
      3'd2: begin
        mreq.a = MUL_A_W'(rate_r);
        mreq.b = MUL_B_W'({1'b0, interval_r});
      end
      3'd3: begin
        mreq.a = MUL_A_W'(pos_diff);
        mreq.b = MUL_B_W'({1'b0, tick_rate_r});
      end
      3'd4: begin
        mreq.a = MUL_A_W'(sp_r);
        mreq.b = MUL_B_W'(speed_gain_r);
      end
      3'd5: begin
        mreq.a = MUL_A_W'(wpos_r);
        mreq.b = MUL_B_W'(position_gain_r);
      end
      3'd6: begin
        mreq.a = MUL_A_W'(rate_r);
        mreq.b = MUL_B_W'(rate_gain_r);
      end
      default: begin
        mreq.a = MUL_A_W'(angle_r);
        mreq.b = MUL_B_W'(angle_gain_r);
      end
    endcase
  end

  brc_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign div_start = (state_r == ST_CAL) && batch_end && batch_good;

  brc_const_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_nxt, 16'd0}),
    .done     (div_done),
    .quotient (div_q)
  );

  // drive: truncate the Q.24 sum toward zero, then clamp
  logic               acc_neg;
  logic [ACC_W-1:0]   acc_mag;
  logic [7:0]         mag_lim;
  logic signed [7:0]  drive_fin;

  assign acc_neg = acc_r[ACC_W-1];
  assign acc_mag = acc_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign mag_lim = ((|acc_mag[ACC_W-1:31]) || (acc_mag[30:24] > 7'(DRIVE_LIMIT)))
                   ? 8'(DRIVE_LIMIT) : {1'b0, acc_mag[30:24]};
  assign drive_fin = acc_neg ? -$signed(mag_lim) : $signed(mag_lim);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = in_cal_r ? ST_CAL : ST_MUL;
      ST_CAL:  state_nxt = div_start ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_MUL:  if (mrsp.done && mul_run_r && step_r == 3'd7) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_gain_r     <= 16'sd294;
      angle_gain_r    <= 16'sd1920;
      speed_gain_r    <= 16'sd51;
      position_gain_r <= 16'sd36;
      track_r         <= 16'd33;
      interval_r      <= 16'd524;
      tick_rate_r     <= 10'd125;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RATE_GAIN:     rate_gain_r     <= cfg_data;
        CFG_ANGLE_GAIN:    angle_gain_r    <= cfg_data;
        CFG_SPEED_GAIN:    speed_gain_r    <= cfg_data;
        CFG_POSITION_GAIN: position_gain_r <= cfg_data;
        CFG_OFFSET_TRACK:  track_r         <= cfg_data;
        CFG_TICK_INTERVAL: interval_r      <= cfg_data;
        CFG_TICK_RATE:     tick_rate_r     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // controller state and sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      angle_r   <= '0;
      wpos_r    <= '0;
      sum_r     <= '0;
      min_r     <= 10'd1023;
      max_r     <= '0;
      count_r   <= '0;
      in_cal_r  <= 1'b1;
      spread_r  <= '0;
      step_r    <= '0;
      mul_run_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          step_r    <= '0;
          mul_run_r <= 1'b0;
        end
        ST_CAL: begin
          if (batch_end) begin
            spread_r <= diff_mm;
            if (batch_good) in_cal_r <= 1'b0;
            sum_r   <= '0;
            min_r   <= 10'd1023;
            max_r   <= '0;
            count_r <= '0;
          end else begin
            sum_r   <= sum_nxt;
            min_r   <= min_nxt;
            max_r   <= max_nxt;
            count_r <= count_nxt;
          end
        end
        ST_DIV: if (div_done) offset_r <= div_q;
        ST_MUL: begin
          if (!mul_run_r) begin
            mul_run_r <= 1'b1;
          end else if (mrsp.done) begin
            mul_run_r <= 1'b0;
            step_r    <= step_r + 1'b1;
            case (step_r)
              3'd1: offset_r <= off_new;
              3'd2: begin
                if (angle_sum[39:31] != {9{angle_sum[39]}})
                  angle_r <= angle_sum[39] ? 32'sh80000000 : 32'sh7fffffff;
                else
                  angle_r <= angle_sum[31:0];
              end
              3'd3: wpos_r <= pos_now;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // tick working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      g_r     <= in_gyro_sample;
      left_r  <= in_left_count;
      right_r <= in_right_count;
    end
    if (state_r == ST_CAL) res_drive_r <= '0;
    if (state_r == ST_FIN) res_drive_r <= drive_fin;
    if (state_r == ST_MUL && mul_run_r && mrsp.done) begin
      case (step_r)
        3'd0: tmp_r <= mrsp.p[OFF_W+15:16];
        3'd1: rate_r <= $signed({1'b0, g_r, 16'd0}) - $signed({1'b0, off_new});
        3'd3: sp_r <= mrsp.p[35:0];
        3'd4: acc_r <= {mrsp.p, 15'd0};
        3'd5: acc_r <= acc_r + {mrsp.p, 15'd0};
        3'd6: acc_r <= acc_r + ACC_W'(mrsp.p);
        3'd7: acc_r <= acc_r + ACC_W'(mrsp.p);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_drive_r  <= res_drive_r;
      out_cal_r    <= in_cal_r;
      out_spread_r <= spread_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive        = out_drive_r;
  assign out_calibrating  = out_cal_r;
  assign out_batch_spread = out_spread_r;

endmodule

/* hdl/brc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the balance controller, bound to the top level.
// Depends on balance_robot_controller ports only.
module brc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_drive,
  input logic              out_calibrating
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive))
    else $error("result changed while stalled");

  // drive stays within the clamp
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive <= 8'sd100) && (out_drive >= -8'sd100))
    else $error("drive out of range");

  // no drive while calibrating
  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_calibrating |-> out_drive == 8'sd0)
    else $error("drive during calibration");

  // one tick at a time: busy right after a transfer in
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // nothing shows right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind balance_robot_controller brc_checker u_brc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_drive       (out_drive),
  .out_calibrating (out_calibrating)
);

/* sim/tb_balance_robot_controller.sv */
`timescale 1ns / 1ps
// Testbench for balance_robot_controller: random and directed ticks through
// calibration and balancing, checked against a cycle-free predictor.
// Depends on brc_pkg and the balance_robot_controller RTL.

// One predicted result per accepted tick
typedef struct {
  logic signed [7:0] drive;
  logic              calibrating;
  logic [9:0]        batch_spread;
} tick_result_t;

// Predictor plus queue of expected results
class balance_scoreboard;
  longint rate_k, angle_k, speed_k, pos_k;
  longint track_w, dt, ticks_per_s;
  longint offset, tilt, wheel_pos;
  int     b_sum, b_min, b_max, b_cnt, spread;
  bit     calib;
  int     errors;
  tick_result_t pending_drives[$];

  function new();
    rate_k = 294; angle_k = 1920; speed_k = 51; pos_k = 36;
    track_w = 33; dt = 524; ticks_per_s = 125;
    offset = 0; tilt = 0; wheel_pos = 0;
    b_sum = 0; b_min = 1023; b_max = 0; b_cnt = 0;
    calib = 1; spread = 0; errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      brc_pkg::CFG_RATE_GAIN:     rate_k      = longint'($signed(data));
      brc_pkg::CFG_ANGLE_GAIN:    angle_k     = longint'($signed(data));
      brc_pkg::CFG_SPEED_GAIN:    speed_k     = longint'($signed(data));
      brc_pkg::CFG_POSITION_GAIN: pos_k       = longint'($signed(data));
      brc_pkg::CFG_OFFSET_TRACK:  track_w     = longint'(data);
      brc_pkg::CFG_TICK_INTERVAL: dt          = longint'(data);
      brc_pkg::CFG_TICK_RATE:     ticks_per_s = longint'(data[9:0]);
      default: ;
    endcase
  endfunction

  // Work out the result of one accepted tick
  function void note_tick(logic [9:0] g, logic signed [23:0] l, logic signed [23:0] r);
    tick_result_t res;
    longint gl, rate, step, prev, pos, a, b, t, q;
    q = 0;
    gl = longint'(g);
    if (calib) begin
      b_sum += g;
      if (g < b_min) b_min = g;
      if (g > b_max) b_max = g;
      b_cnt++;
      if (b_cnt >= brc_pkg::CALIB_SAMPLES) begin
        spread = (b_max - b_min) & 1023;
        if (b_max - b_min <= 1) begin
          offset = ((longint'(b_sum) << 16) / brc_pkg::CALIB_SAMPLES) & 64'h3FF_FFFF;
          calib = 0;
        end
        b_sum = 0; b_min = 1023; b_max = 0; b_cnt = 0;
      end
    end else begin
      offset = ((track_w * (gl << 16) + (65536 - track_w) * offset) >> 16)
               & 64'h3FF_FFFF;
      rate = (gl << 16) - offset;
      step = (rate * dt) >>> 16;
      tilt += step;
      if (tilt > 64'sd2147483647) tilt = 64'sd2147483647;
      if (tilt < -64'sd2147483648) tilt = -64'sd2147483648;
      prev = wheel_pos;
      pos = longint'(l) + longint'(r);
      wheel_pos = pos;
      a = rate_k * rate + angle_k * tilt;
      b = speed_k * ((pos - prev) * ticks_per_s) + pos_k * pos;
      t = b + (a >>> 15);
      q = t >>> 9;
      // truncate toward zero unless the negative sum is exact
      if (t < 0 && !(((t & 511) == 0) && ((a & 32767) == 0))) q += 1;
      if (q > brc_pkg::DRIVE_LIMIT) q = brc_pkg::DRIVE_LIMIT;
      if (q < -brc_pkg::DRIVE_LIMIT) q = -brc_pkg::DRIVE_LIMIT;
    end
    res.drive = q[7:0];
    res.calibrating = calib;
    res.batch_spread = spread[9:0];
    pending_drives.push_back(res);
  endfunction

  function void check_result(logic signed [7:0] d, logic c, logic [9:0] s);
    tick_result_t e;
    if (pending_drives.size() == 0) begin
      $error("result transfer with no tick outstanding");
      errors++;
      return;
    end
    e = pending_drives.pop_front();
    if (d !== e.drive) begin
      $error("drive: expected %0d, actual %0d", e.drive, d);
      errors++;
    end
    if (c !== e.calibrating) begin
      $error("calibrating: expected %0d, actual %0d", e.calibrating, c);
      errors++;
    end
    if (s !== e.batch_spread) begin
      $error("batch_spread: expected %0d, actual %0d", e.batch_spread, s);
      errors++;
    end
  endfunction
endclass

module tb_balance_robot_controller;
  import brc_pkg::*;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [2:0]  CFG_UNUSED  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [9:0]  in_gyro_sample = '0;
  logic signed [23:0] in_left_count = '0;
  logic signed [23:0] in_right_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [7:0] out_drive;
  logic        out_calibrating;
  logic [9:0]  out_batch_spread;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  balance_scoreboard sb = new();
  bit  quiet = 1'b0;
  int  cycles = 0;
  int  wheel = 0;

  balance_robot_controller dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random back-pressure, check every transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_drive, out_calibrating, out_batch_spread);
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
  end

  task automatic send_tick(logic [9:0] g, logic signed [23:0] l, logic signed [23:0] r);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_gyro_sample <= g;
    in_left_count <= l;
    in_right_count <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(g, l, r);
  endtask

  // Stop the input side and let every result drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_drives.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_regs(logic [15:0] v[7]);
    for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), v[i]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Balancing tick: mostly gyro near its rest value and wheels drifting slowly
  task automatic random_tick(int bias);
    logic [9:0] g;
    logic signed [23:0] l, r;
    int k;
    k = $urandom_range(99);
    if (bias == 1) g = 10'd1023;
    else if (bias == 2) g = 10'd0;
    else if (k < 70) g = 10'(512 + $urandom_range(0, 16) - 8);
    else g = 10'($urandom);
    if ($urandom_range(99) < 80) begin
      wheel += $urandom_range(0, 200) - 100;
      l = 24'(wheel + $urandom_range(0, 20));
      r = 24'(wheel - $urandom_range(0, 20));
    end else begin
      l = 24'($urandom);
      r = 24'($urandom);
    end
    send_tick(g, l, r);
  endtask

  initial begin
    logic [15:0] regs[7];
    int base;
    int errs;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unknown register index is ignored
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);

    // Calibration: noisy batch, then a batch one past the allowed spread
    send_tick(10'd0, 24'sh7FFFFF, 24'sh800000);
    send_tick(10'd1023, 24'sh800000, 24'sh7FFFFF);
    for (int i = 2; i < CALIB_SAMPLES; i++)
      send_tick(10'($urandom), 24'($urandom), 24'($urandom));
    base = $urandom_range(0, 1021);
    for (int i = 0; i < CALIB_SAMPLES; i++)
      send_tick(10'(base + (i == 0 ? 0 : (i == 1 ? 2 : $urandom_range(0, 2)))),
                24'($urandom), 24'($urandom));
    // Good batch; its last tick ends calibration
    base = $urandom_range(500, 520);
    for (int i = 0; i < CALIB_SAMPLES; i++)
      send_tick(10'(base + $urandom_range(0, 1)), 24'($urandom), 24'($urandom));

    // Directed balancing ticks: count and gyro extremes, large speed jumps
    send_tick(10'(base), 24'sd0, 24'sd0);
    send_tick(10'(base), 24'sh7FFFFF, 24'sh7FFFFF);
    send_tick(10'(base), 24'sh800000, 24'sh800000);
    send_tick(10'(base), 24'sh7FFFFF, 24'sh800000);
    send_tick(10'd1023, 24'sd0, 24'sd0);
    send_tick(10'd0, 24'sd1, 24'sd0);
    send_tick(10'd0, -24'sd1, 24'sd0);
    send_tick(10'd1023, 24'sd5, 24'sd5);
    drain();

    // Phase settings, from defaults to extremes and random
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: regs = '{16'd294, 16'd1920, 16'd51, 16'd36, 16'd33, 16'd524, 16'd125};
        1: regs = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'hFFFF, 16'd1000};
        2: regs = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'd0, 16'd0};
        3: regs = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'h03FF};
        4: regs = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom)};
        default: regs = '{16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)),
                          16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                          16'($urandom_range(0, 200)), 16'($urandom_range(1, 2000)),
                          16'($urandom_range(1, 200))};
      endcase
      set_regs(regs);
      quiet = (ph == 0);
      for (int i = 0; i < 35; i++) begin
        // phase 1 swings the angle hard one way, then back
        if (ph == 1) random_tick(i < 25 ? 1 : 2);
        else random_tick(0);
      end
      drain();
      quiet = 1'b0;
    end

    errs = sb.errors + sb.pending_drives.size();
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/brc_pkg.sv
hdl/brc_serial_mul.sv
hdl/brc_const_div.sv
hdl/balance_robot_controller.sv
hdl/brc_checker.sv
sim/tb_balance_robot_controller.sv
